[sv/cv3_pkg.sv]
// Shared types and constants of the 3x3 zero-padded convolution filter.
package cv3_pkg;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int RAW_W_BITS    = 11;
    localparam int ROW_BITS      = 16;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH   = 3'd0,
        CFG_IMAGE_HEIGHT  = 3'd1,
        CFG_KERNEL_TOP    = 3'd2,
        CFG_KERNEL_MIDDLE = 3'd3,
        CFG_KERNEL_BOTTOM = 3'd4
    } t_cfg_idx;

    // Reset values of the registers
    localparam logic [RAW_W_BITS-1:0]    RST_WIDTH  = 11'd1024;
    localparam logic [ROW_BITS-1:0]      RST_HEIGHT = 16'd1024;
    localparam logic [CFG_DATA_BITS-1:0] RST_K_TOP  = 24'd65280;
    localparam logic [CFG_DATA_BITS-1:0] RST_K_MID  = 24'd16713215;
    localparam logic [CFG_DATA_BITS-1:0] RST_K_BOT  = 24'd65280;

    // Item kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Result format and output queue
    localparam int RESULT_BITS   = 20;
    localparam int SLOT_BITS     = 8;
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_IDX_BITS = 3;

    // Per-item tag carried down the arithmetic pipeline
    typedef struct packed {
        logic alive;   // an accepted item occupies this stage
        logic res;     // the item yields a result
        logic last;    // result closes the frame
    } t_tag;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] filtered_value;
        logic                          end_of_frame;
    } t_result;

endpackage

[sv/cv3_if.sv]
// Handshake interfaces for the pixel input and the filtered result output.
interface cv3_pix_if #(
    parameter int PIXEL_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [PIXEL_BITS-1:0] pixel;

    modport source(output valid, req_type, pixel, input ready);
    modport sink(input valid, req_type, pixel, output ready);
endinterface

interface cv3_res_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] filtered_value;
    logic               end_of_frame;

    modport source(output valid, filtered_value, end_of_frame, input ready);
    modport sink(input valid, filtered_value, end_of_frame, output ready);
endinterface

[sv/cv3_mac.sv]
// Three-stage multiply and adder tree over the 3x3 window.
module cv3_mac #(
    parameter int PIXEL_BITS = 8,
    parameter int COEFF_BITS = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  cv3_pkg::t_tag                               i_tag,
    input  logic [2:0][2:0][PIXEL_BITS-1:0]             i_pix,
    input  logic [2:0][cv3_pkg::CFG_DATA_BITS-1:0]      i_kernel,
    output cv3_pkg::t_tag                               o_tag,
    output logic signed [cv3_pkg::RESULT_BITS-1:0]      o_sum
);
    import cv3_pkg::*;

    localparam int PW = PIXEL_BITS + COEFF_BITS + 1;
    localparam int RW = PW + 2;
    localparam int SW = PW + 4;
    localparam int EW = (SW > RESULT_BITS) ? SW : RESULT_BITS;

    logic signed [PW-1:0] n_prod [3][3];
    logic signed [PW-1:0] r_prod [3][3];
    logic signed [RW-1:0] n_row  [3];
    logic signed [RW-1:0] r_row  [3];
    logic signed [SW-1:0] n_sum;
    logic signed [EW-1:0] sum_ext;
    t_tag                 r_tag_a;
    t_tag                 r_tag_b;
    t_tag                 r_tag_c;
    logic signed [RESULT_BITS-1:0] r_sum;

    // Multiply each tap by its signed coefficient
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_prod[i][j] = PW'($signed(i_kernel[i][SLOT_BITS*j +: COEFF_BITS]))
                             * PW'($signed({1'b0, i_pix[i][j]}));
            end
        end
    end

    // Sum each kernel row
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_row[i] = RW'(r_prod[i][0]) + RW'(r_prod[i][1]) + RW'(r_prod[i][2]);
        end
    end

    // Total, wrapped to the result width
    assign n_sum   = SW'(r_row[0]) + SW'(r_row[1]) + SW'(r_row[2]);
    assign sum_ext = EW'(n_sum);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_row  <= n_row;
        r_sum  <= sum_ext[RESULT_BITS-1:0];
    end

    // Advance the tags alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;
        end
    end

    assign o_tag = r_tag_c;
    assign o_sum = r_sum;

endmodule

[sv/cv3_fifo.sv]
// Small result queue that decouples the pipeline from the output sink.
module cv3_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cv3_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output cv3_pkg::t_result o_data
);
    import cv3_pkg::*;

    t_result                  r_mem [FIFO_DEPTH];
    logic [FIFO_IDX_BITS-1:0] r_wr_ptr;
    logic [FIFO_IDX_BITS-1:0] r_rd_ptr;
    logic [FIFO_IDX_BITS:0]   r_count;
    logic [FIFO_IDX_BITS:0]   n_count;

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

[sv/conv3x3_zero_pad_filter.sv]
// Top level: 3x3 convolution with zero halo over a raster pixel stream.
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+-------------------------------------
//  i_pix     | in  | valid/ready           | req_type, pixel
//  o_res     | out | valid/ready           | filtered_value (s20), end_of_frame
//  i_cfg_*   | in  | write enable, no wait | index (3 b), data (24 b)
//
// One item per clock sustained while o_res.ready holds; the two line stores
// share one memory entry per column that is read on accept and written back
// in the following cycle. A result passes the line store read, window,
// multiply, row sums, total and queue registers, in that order, to the output.
// Reset is synchronous; it clears counters, window and queue but not the line
// store, which needs no clearing pass since rows above the image are masked.
// i_pix.ready drops only when eight items are in flight or queued.
module conv3x3_zero_pad_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8,
    parameter int COEFF_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cv3_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [cv3_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    cv3_pix_if.sink                             i_pix,
    cv3_res_if.source                           o_res
);
    import cv3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int LW = 2 * PIXEL_BITS;

    // Configuration registers
    logic [WB-1:0]            r_width;
    logic [ROW_BITS-1:0]      r_height;
    logic [2:0][CFG_DATA_BITS-1:0] r_kernel;
    logic [RAW_W_BITS-1:0]    cfg_w_raw;
    logic [ROW_BITS-1:0]      cfg_h_raw;
    logic [WB-1:0]            cfg_w_eff;

    // Position counters
    logic [CW-1:0]            r_col;
    logic [ROW_BITS-1:0]      r_row;
    logic [WB-1:0]            r_flush;
    logic [CW-1:0]            n_col;
    logic [ROW_BITS-1:0]      n_row;
    logic [WB-1:0]            n_flush;

    // Accept-side decode
    logic                     accept;
    logic                     flushing;
    logic                     is_last;
    logic [WB-1:0]            col_clamp;
    logic [WB:0]              col_next;
    logic [CW-1:0]            col_sel;
    logic                     ge1;
    logic                     ge2;
    logic [PIXEL_BITS-1:0]    in_value;

    // Line store stage
    logic [LW-1:0]            r_line [MAX_WIDTH];
    logic [LW-1:0]            r_rd;
    logic                     r_fwd;
    logic [LW-1:0]            r_fwd_data;
    logic                     r_s1_vld;
    logic [CW-1:0]            r_s1_addr;
    logic [PIXEL_BITS-1:0]    r_s1_value;
    logic                     r_s1_ge1;
    logic                     r_s1_ge2;
    logic                     r_s1_c0;
    logic                     r_s1_last;
    logic [LW-1:0]            line_cur;
    logic [LW-1:0]            wr_data;
    logic [PIXEL_BITS-1:0]    above;
    logic [PIXEL_BITS-1:0]    mid;

    // Window stage
    logic [2:0][2:0][PIXEL_BITS-1:0] r_win;
    logic [2:0][2:0][PIXEL_BITS-1:0] n_win;
    logic [2:0][2:0][PIXEL_BITS-1:0] eff;
    logic [2:0][PIXEL_BITS-1:0]      new_col;
    logic [2:0][2:0][PIXEL_BITS-1:0] r_m_pix;
    t_tag                            r_m_tag;
    t_tag                            n_m_tag;

    // Back end
    t_tag                            mac_tag;
    logic signed [RESULT_BITS-1:0]   mac_sum;
    t_result                         push_data;
    t_result                         q_data;
    logic                            q_valid;
    logic                            push;
    logic                            drop;
    logic                            pop;
    logic [FIFO_IDX_BITS:0]          r_used;
    logic [FIFO_IDX_BITS:0]          n_used;

    // Clamp configured sizes as they are written
    assign cfg_w_raw = i_cfg_data[RAW_W_BITS-1:0];
    assign cfg_h_raw = i_cfg_data[ROW_BITS-1:0];

    always_comb begin
        if (cfg_w_raw == '0) begin
            cfg_w_eff = WB'(1);
        end else if (32'(cfg_w_raw) > MAX_WIDTH) begin
            cfg_w_eff = WB'(MAX_WIDTH);
        end else begin
            cfg_w_eff = WB'(cfg_w_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= (32'(RST_WIDTH) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(RST_WIDTH);
            r_height    <= RST_HEIGHT;
            r_kernel[0] <= RST_K_TOP;
            r_kernel[1] <= RST_K_MID;
            r_kernel[2] <= RST_K_BOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:   r_width     <= cfg_w_eff;
                CFG_IMAGE_HEIGHT:  r_height    <= (cfg_h_raw == '0) ? ROW_BITS'(1) : cfg_h_raw;
                CFG_KERNEL_TOP:    r_kernel[0] <= i_cfg_data;
                CFG_KERNEL_MIDDLE: r_kernel[1] <= i_cfg_data;
                CFG_KERNEL_BOTTOM: r_kernel[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Decode the position of the accepted item
    assign accept    = i_pix.valid & i_pix.ready;
    assign flushing  = (r_row >= r_height);
    assign is_last   = flushing && (r_flush >= r_width);
    assign col_clamp = (WB'(r_col) < r_width) ? WB'(r_col) : r_width - 1'b1;
    assign col_next  = {1'b0, col_clamp} + 1'b1;
    assign in_value  = (i_pix.req_type == REQ_PIXEL && !flushing) ? i_pix.pixel : '0;

    always_comb begin
        if (!flushing) begin
            col_sel = col_clamp[CW-1:0];
            ge1     = (r_row != '0);
            ge2     = (r_row > ROW_BITS'(1));
        end else if (!is_last) begin
            col_sel = r_flush[CW-1:0];
            ge1     = 1'b1;
            ge2     = (r_height > ROW_BITS'(1));
        end else begin
            col_sel = '0;
            ge1     = 1'b1;
            ge2     = 1'b1;
        end
    end

    // Step the counters; the last item of a frame returns them to zero
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_flush = r_flush;
        if (is_last) begin
            n_col   = '0;
            n_row   = '0;
            n_flush = '0;
        end else if (!flushing) begin
            if (col_next >= {1'b0, r_width}) begin
                n_col = '0;
                n_row = r_row + 1'b1;
            end else begin
                n_col = col_next[CW-1:0];
            end
        end else begin
            n_flush = r_flush + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_flush <= '0;
        end else if (accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_flush <= n_flush;
        end
    end

    // Entry holds {older row, newer row}; shift it down and write back
    assign line_cur = r_fwd ? r_fwd_data : r_rd;
    assign wr_data  = {line_cur[PIXEL_BITS-1:0], r_s1_value};
    assign above    = r_s1_ge2 ? line_cur[LW-1:PIXEL_BITS] : '0;
    assign mid      = r_s1_ge1 ? line_cur[PIXEL_BITS-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_line[r_s1_addr] <= wr_data;
        end
        if (accept) begin
            r_rd <= r_line[col_sel];
        end
    end

    // Forward a write-back that lands in the same cycle as the read
    always_ff @(posedge i_clk) begin
        r_fwd_data <= wr_data;
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= accept && r_s1_vld && (r_s1_addr == col_sel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_addr  <= col_sel;
            r_s1_value <= in_value;
            r_s1_ge1   <= ge1;
            r_s1_ge2   <= ge2;
            r_s1_c0    <= (col_sel == '0);
            r_s1_last  <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    // Shift the window; column zero starts a row with zeros on its left
    always_comb begin
        new_col[0] = above;
        new_col[1] = mid;
        new_col[2] = r_s1_value;
        for (int i = 0; i < 3; i++) begin
            eff[i][0] = r_win[i][1];
            eff[i][1] = r_win[i][2];
            eff[i][2] = r_s1_c0 ? '0 : new_col[i];
        end
        n_win = eff;
        if (r_s1_last) begin
            n_win = '0;
        end else if (r_s1_c0) begin
            for (int i = 0; i < 3; i++) begin
                n_win[i][0] = '0;
                n_win[i][1] = '0;
                n_win[i][2] = new_col[i];
            end
        end
    end

    always_comb begin
        n_m_tag.alive = r_s1_vld;
        n_m_tag.res   = r_s1_vld && (r_s1_c0 ? r_s1_ge2 : r_s1_ge1);
        n_m_tag.last  = r_s1_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_m_tag <= '0;
        end else begin
            if (r_s1_vld) begin
                r_win <= n_win;
            end
            r_m_tag <= n_m_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_pix <= eff;
    end

    cv3_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEFF_BITS (COEFF_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (r_m_tag),
        .i_pix    (r_m_pix),
        .i_kernel (r_kernel),
        .o_tag    (mac_tag),
        .o_sum    (mac_sum)
    );

    // Queue results; items without a result just release their credit
    assign push = mac_tag.alive & mac_tag.res;
    assign drop = mac_tag.alive & ~mac_tag.res;
    assign push_data.filtered_value = mac_sum;
    assign push_data.end_of_frame   = mac_tag.last;
    assign pop  = q_valid & o_res.ready;

    cv3_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // Count items in flight or queued; hold off input when the queue could fill
    assign n_used = r_used + {{FIFO_IDX_BITS{1'b0}}, accept}
                           - {{FIFO_IDX_BITS{1'b0}}, pop}
                           - {{FIFO_IDX_BITS{1'b0}}, drop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    assign i_pix.ready          = (r_used < (FIFO_IDX_BITS+1)'(FIFO_DEPTH));
    assign o_res.valid          = q_valid;
    assign o_res.filtered_value = q_data.filtered_value;
    assign o_res.end_of_frame   = q_data.end_of_frame;

endmodule

[sv/cv3_chk.sv]
// Port-level checks of the convolution filter, bound to its top level.
module cv3_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [19:0] i_out_value,
    input logic        i_out_eof
);
    // Accept to first visible result
    localparam int LATENCY = 6;

    logic in_acc;

    assign in_acc = i_in_valid & i_in_ready;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_eof))
        else $error("stalled result changed");

    // Leaving reset: queue empty, input open
    a_reset_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("bad state after reset");

    // A result appears on an empty output only after a matching accept
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(in_acc, LATENCY))
        else $error("result without matching item");

    // Input closes only after taking an item
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(in_acc))
        else $error("ready dropped without an accept");

endmodule

bind conv3x3_zero_pad_filter cv3_chk u_cv3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_value (o_res.filtered_value),
    .i_out_eof   (o_res.end_of_frame)
);
